// ----- sv/tabc_pkg.sv -----
package tabc_pkg;

    // Item selector carried on s_tuser
    typedef enum logic [1:0] {
        CMD_EVENT   = 2'd0,
        CMD_FORK    = 2'd1,
        CMD_THERMAL = 2'd2,
        CMD_TICK    = 2'd3
    } cmd_t;

    // Boost kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_TOUCH  = 2'd1;
    localparam logic [1:0] KIND_LAUNCH = 2'd2;

    // Heat levels
    localparam logic [1:0] HEAT_COOL = 2'd0;
    localparam logic [1:0] HEAT_WARM = 2'd1;
    localparam logic [1:0] HEAT_HOT  = 2'd2;

    // Input event codes
    localparam logic [4:0] EV_KEY          = 5'd1;
    localparam logic [4:0] EV_ABS          = 5'd3;
    localparam logic [9:0] ABS_TRACKING_ID = 10'h039;
    localparam logic [9:0] ABS_POSITION_X  = 10'h035;
    localparam logic [9:0] KEY_TOUCH_CODE  = 10'h14a;

    localparam logic [6:0] PRESS_HOT_PCT  = 7'd60;
    localparam logic [6:0] PRESS_WARM_PCT = 7'd20;
    localparam logic [6:0] CEIL_MAX       = 7'd100;
    localparam logic [6:0] CEIL_STEP      = 7'd5;

    // Configuration register indexes
    localparam int          CFG_ADDR_W = 3;
    localparam int          CFG_DATA_W = 14;
    localparam logic [2:0]  REG_ENABLE        = 3'd0;
    localparam logic [2:0]  REG_LAUNCH_ENABLE = 3'd1;
    localparam logic [2:0]  REG_TOUCH_HOLD    = 3'd2;
    localparam logic [2:0]  REG_LAUNCH_HOLD   = 3'd3;
    localparam logic [2:0]  REG_LOAD_THRESH   = 3'd4;
    localparam logic [2:0]  REG_HOT_TEMP      = 3'd5;
    localparam logic [2:0]  REG_WARM_TEMP     = 3'd6;
    localparam logic [2:0]  REG_HOT_CEILING   = 3'd7;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 16;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;    // capture the accepted item
        logic calc;    // products and limits into registers
        logic commit;  // update state and load the output register
    } ctrl_t;

endpackage

// ----- sv/tabc_ctrl.sv -----
module tabc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output tabc_pkg::ctrl_t  ctrl
);
    import tabc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // output register is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        ctrl           = '0;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                ctrl.calc  = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    ctrl.commit    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

// ----- sv/tabc_dp.sv -----
module tabc_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tabc_pkg::ctrl_t                 ctrl,
    input  logic [1:0]                      s_tuser,
    input  logic [tabc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            cfg_we,
    input  logic [tabc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tabc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic [tabc_pkg::M_TDATA_W-1:0]  m_tdata
);
    import tabc_pkg::*;

    // configuration
    logic               en_reg, len_reg;
    logic [13:0]        thold_reg, lhold_reg;
    logic [6:0]         thr_reg, hceil_reg;
    logic signed [8:0]  hot_t_reg, warm_t_reg;

    // captured item
    cmd_t               cmd_reg;
    logic [4:0]         type_reg;
    logic [9:0]         code_reg;
    logic signed [31:0] value_reg;
    logic [10:0]        util_reg, cap_reg, press_reg;
    logic signed [19:0] temp_reg;

    // products and limits
    logic [17:0]        util100_reg, util100_next;
    logic [17:0]        loadlim_reg, loadlim_next;
    logic [7:0]         pct_reg, pct_next;
    logic signed [20:0] hot_lim_reg, hot_lim_next;
    logic signed [20:0] warm_lim_reg, warm_lim_next;
    logic [17:0]        press100;

    // block state
    logic [1:0]         kind_reg, kind_next;
    logic [13:0]        hold_reg, hold_next;
    logic [1:0]         heat_reg, heat_next;
    logic [6:0]         ceil_reg, ceil_next;
    logic               fired;
    logic [11:0]        out_reg;

    // signed limit so that trunc(t/1000) > h becomes t >= limit
    function automatic logic signed [20:0] temp_limit(input logic signed [8:0] h);
        logic signed [20:0] hx;
        begin
            hx = {{12{h[8]}}, h};
            if (h[8])
                temp_limit = hx * 21'sd1000 + 21'sd1;
            else
                temp_limit = (hx + 21'sd1) * 21'sd1000;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg     <= 1'b1;
            len_reg    <= 1'b1;
            thold_reg  <= 14'd100;
            lhold_reg  <= 14'd500;
            thr_reg    <= 7'd40;
            hot_t_reg  <= 9'sd52;
            warm_t_reg <= 9'sd42;
            hceil_reg  <= 7'd75;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ENABLE:        en_reg     <= cfg_wdata[0];
                REG_LAUNCH_ENABLE: len_reg    <= cfg_wdata[0];
                REG_TOUCH_HOLD:    thold_reg  <= cfg_wdata[13:0];
                REG_LAUNCH_HOLD:   lhold_reg  <= cfg_wdata[13:0];
                REG_LOAD_THRESH:   thr_reg    <= cfg_wdata[6:0];
                REG_HOT_TEMP:      hot_t_reg  <= cfg_wdata[8:0];
                REG_WARM_TEMP:     warm_t_reg <= cfg_wdata[8:0];
                REG_HOT_CEILING:   hceil_reg  <= cfg_wdata[6:0];
                default:           en_reg     <= en_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg   <= cmd_t'(s_tuser);
            type_reg  <= s_tdata[4:0];
            code_reg  <= s_tdata[14:5];
            value_reg <= s_tdata[46:15];
            util_reg  <= s_tdata[57:47];
            cap_reg   <= s_tdata[68:58];
            press_reg <= s_tdata[79:69];
            temp_reg  <= s_tdata[100] ? s_tdata[99:80] : 20'sd0;
        end
    end

    // util*100/cap > thr  <=>  util*100 >= (thr+1)*cap, for cap != 0
    assign press100      = 18'(press_reg) * 18'd100;
    assign util100_next  = 18'(util_reg) * 18'd100;
    assign loadlim_next  = (18'(thr_reg) + 18'd1) * 18'(cap_reg);
    assign pct_next      = press100[17:10];
    assign hot_lim_next  = temp_limit(hot_t_reg);
    assign warm_lim_next = temp_limit(warm_t_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.calc)
        begin
            util100_reg  <= util100_next;
            loadlim_reg  <= loadlim_next;
            pct_reg      <= pct_next;
            hot_lim_reg  <= hot_lim_next;
            warm_lim_reg <= warm_lim_next;
        end
    end

    always_comb
    begin
        logic       req;
        logic [1:0] req_kind;
        logic [13:0] hold_sel;
        logic [6:0] ceil_up;
        req       = 1'b0;
        req_kind  = KIND_TOUCH;
        kind_next = kind_reg;
        hold_next = hold_reg;
        heat_next = heat_reg;
        ceil_next = ceil_reg;
        fired     = 1'b0;
        ceil_up   = ceil_reg + CEIL_STEP;
        case (cmd_reg)
            CMD_EVENT:
            begin
                req_kind = KIND_TOUCH;
                req = en_reg && (value_reg > 32'sd0) &&
                      ((type_reg == EV_ABS && (code_reg == ABS_TRACKING_ID ||
                                               code_reg == ABS_POSITION_X)) ||
                       (type_reg == EV_KEY && code_reg == KEY_TOUCH_CODE));
            end
            CMD_FORK:
            begin
                req_kind = KIND_LAUNCH;
                req = (cap_reg != 11'd0) && (util100_reg >= loadlim_reg);
            end
            CMD_THERMAL:
            begin
                if (pct_reg > PRESS_HOT_PCT || 21'(temp_reg) >= hot_lim_reg)
                begin
                    heat_next = HEAT_HOT;
                    ceil_next = (hceil_reg > CEIL_MAX) ? CEIL_MAX : hceil_reg;
                end
                else
                begin
                    heat_next = (pct_reg > PRESS_WARM_PCT ||
                                 21'(temp_reg) >= warm_lim_reg) ? HEAT_WARM : HEAT_COOL;
                    if (ceil_reg < CEIL_MAX)
                        ceil_next = (ceil_up > CEIL_MAX) ? CEIL_MAX : ceil_up;
                end
            end
            CMD_TICK:
            begin
                if (hold_reg != 14'd0)
                begin
                    hold_next = hold_reg - 14'd1;
                    if (hold_reg == 14'd1)
                        kind_next = KIND_NONE;
                end
            end
            default:
            begin
                req = 1'b0;
            end
        endcase

        hold_sel = (req_kind == KIND_TOUCH) ? thold_reg : lhold_reg;
        // launch never displaces a running touch boost
        if (req && en_reg && !(req_kind == KIND_LAUNCH && !len_reg) &&
            heat_reg != HEAT_HOT &&
            !(kind_reg == KIND_TOUCH && req_kind == KIND_LAUNCH))
        begin
            fired     = 1'b1;
            kind_next = req_kind;
            hold_next = (hold_sel == 14'd0) ? 14'd1 : hold_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_NONE;
            hold_reg <= 14'd0;
            heat_reg <= HEAT_COOL;
            ceil_reg <= CEIL_MAX;
        end
        else if (ctrl.commit)
        begin
            kind_reg <= kind_next;
            hold_reg <= hold_next;
            heat_reg <= heat_next;
            ceil_reg <= ceil_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            out_reg <= {ceil_next, heat_next, fired, kind_next};
        end
    end

    assign m_tdata = {4'd0, out_reg};

endmodule

// ----- sv/thermal_aware_boost_coordinator_top.sv -----
// Boost coordinator: one result item for every input item.
//
// Input channel s_*: s_tuser carries the command (event, fork, thermal
// sample, millisecond tick); s_tdata carries the operand fields. Output
// channel m_*: m_tdata carries the boost and thermal status after the item.
// Configuration: cfg_we/cfg_addr/cfg_wdata write one register per cycle;
// users must write only while no item is in flight (not enforced).
//
// Each item passes through capture (ST_IDLE), the load cross-multiply,
// pressure percent and temperature limits (ST_CALC), and the state update
// that loads the output register (ST_COMMIT). The controller holds one item
// at a time, so it takes no new item until the last one is committed.
// The output register lets the next item be taken and worked on while a
// result waits; if m_tready is held low, the second item stalls in its
// update cycle and s_tready stays low until the output register frees.
//
// Reset: registers return to their defaults (enable on, holds 100/500 ms,
// threshold 40, hot 52 C, warm 42 C, hot ceiling 75), no boost, cool, ceiling
// 100, output empty. No clearing pass; the block takes items right away.
module thermal_aware_boost_coordinator_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tuser: cmd[1:0]
    input  logic [1:0]                      s_tuser,
    // s_tdata: ev_type[4:0], ev_code[14:5], ev_value[46:15], cpu_util[57:47],
    // cpu_capacity[68:58], pressure[79:69], temp_milli_c[99:80],
    // temp_valid[100], zero[103:101]
    input  logic [tabc_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: active_boost[1:0], boost_fired[2], thermal_level[4:3],
    // ceiling_pct[11:5], zero[15:12]
    output logic [tabc_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_we,
    input  logic [tabc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tabc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tabc_pkg::*;

    ctrl_t ctrl;

    tabc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    tabc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata)
    );

    // one item at a time: no new item in the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while another in flight");

    // a result is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.commit && m_tvalid) |-> m_tready)
        else $error("output register overwritten");

    // a granted boost leaves an active boost behind
    a_fired_active: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] != KIND_NONE))
        else $error("boost fired with no active boost");

    // ceiling stays within range and boost kind is never the unused code
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[11:5] <= CEIL_MAX && m_tdata[1:0] != 2'd3))
        else $error("result field out of range");

endmodule
